### hw/rtl/aobd_pkg.sv
// Package for the converter oversampling and wire-break sequencer.
// Holds field widths, stream packing offsets, phase/action/register codes and lane control type.
// No dependencies.
package aobd_pkg;

  // Field widths
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int SUM_BITS    = 27;
  localparam int TIMER_BITS  = 8;
  localparam int COUNT_BITS  = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;

  // Input stream packing: tick, ready_low, then the samples
  localparam int IN_FIELD_BITS = 2 + CHANNELS * SAMPLE_BITS;
  localparam int IN_DATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_SAMPLE_LSB = 2;

  // Output stream packing: action, sums_valid, sums, break_flags, current_on, phase
  localparam int OUT_FIELD_BITS = 2 + 1 + CHANNELS * SUM_BITS + CHANNELS + 1 + 2;
  localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Configuration reset values
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = 24'hC0_0000;
  localparam logic [COUNT_BITS-1:0]  SPS_RST       = 4'd8;
  localparam logic [TIMER_BITS-1:0]  TIMEOUT_RST   = 8'd10;
  localparam logic [TIMER_BITS-1:0]  MIN_CONV_RST  = 8'd1;
  localparam logic [TIMER_BITS-1:0]  TIMER_MAX     = 8'hFF;

  typedef enum logic [1:0] {
    PH_MEASURE = 2'd0,
    PH_CHECK   = 2'd1,
    PH_FAIL    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_CHECK   = 2'd2,
    ACT_REINIT  = 2'd3
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SPS       = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_MIN_CONV  = 2'd3
  } cfg_reg_t;

  // Per-poll commands from the sequencer to every lane
  typedef struct packed {
    logic step;     // transaction taken, lane state may update
    logic add;      // add sample to accumulator
    logic publish;  // move accumulated sum to published, clear accumulator
    logic check;    // compare sample against break threshold
  } lane_ctrl_t;

endpackage

### hw/rtl/adc_oversample_break_detect_sequencer.sv
// Oversampling sequencer for four lockstep converters with wire-break detection. One poll
// transaction in gives one result transaction out. A poll is taken every clock cycle while the
// two-entry output buffer has room; the whole poll (timer update, four parallel lane adds and
// threshold compares, phase decision) is computed combinationally and its result is registered
// in that buffer. The configuration port is a plain write port and should only be written
// while idle. Depends on aobd_pkg, aobd_ctrl, aobd_lane and aobd_skid.
module adc_oversample_break_detect_sequencer
  import aobd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Poll stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tick, ready_low, sample_a, sample_b, sample_c, sample_d (lowest first)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // action, sums_valid, sum_a, sum_b, sum_c, sum_d, break_flags, current_on, phase
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [SAMPLE_BITS-1:0] threshold_r;
  logic [COUNT_BITS-1:0]  sps_r;
  logic [TIMER_BITS-1:0]  timeout_r;
  logic [TIMER_BITS-1:0]  min_conv_r;

  logic                                step;
  lane_ctrl_t                          lane_ctrl;
  action_t                             action;
  logic                                sums_valid;
  logic                                current_nxt;
  phase_t                              phase_nxt;
  logic [CHANNELS-1:0][SUM_BITS-1:0]   pub_nxt;
  logic [CHANNELS-1:0]                 brk_nxt;
  logic [OUT_FIELD_BITS-1:0]           res_fields;
  logic [OUT_DATA_W-1:0]               res_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      sps_r       <= SPS_RST;
      timeout_r   <= TIMEOUT_RST;
      min_conv_r  <= MIN_CONV_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD: threshold_r <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_SPS:       sps_r       <= cfg_wdata[COUNT_BITS-1:0];
        REG_TIMEOUT:   timeout_r   <= cfg_wdata[TIMER_BITS-1:0];
        REG_MIN_CONV:  min_conv_r  <= cfg_wdata[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign step = in_tvalid && in_tready;

  // Phase sequencer
  aobd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .tick            (in_tdata[0]),
    .ready_low       (in_tdata[1]),
    .samples_per_sum (sps_r),
    .timeout_ticks   (timeout_r),
    .min_conv_ticks  (min_conv_r),
    .lane_ctrl       (lane_ctrl),
    .action          (action),
    .sums_valid      (sums_valid),
    .current_nxt     (current_nxt),
    .phase_nxt       (phase_nxt)
  );

  // One lane per converter channel
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    aobd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl),
      .sample    (in_tdata[IN_SAMPLE_LSB + i*SAMPLE_BITS +: SAMPLE_BITS]),
      .threshold (threshold_r),
      .pub_nxt   (pub_nxt[i]),
      .brk_nxt   (brk_nxt[i])
    );
  end

  // Merge lane results with sequencer outputs
  assign res_fields = {phase_nxt, current_nxt, brk_nxt, pub_nxt, sums_valid, action};
  assign res_data   = OUT_DATA_W'(res_fields);

  aobd_skid #(
    .WIDTH (OUT_DATA_W)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res_data),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_ready (out_tready)
  );

endmodule

### hw/rtl/aobd_lane.sv
// One channel lane: saturating accumulator, published sum and break flag.
// Depends on aobd_pkg.
module aobd_lane
  import aobd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lane_ctrl_t             ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] threshold,
  output logic [SUM_BITS-1:0]    pub_nxt,
  output logic                   brk_nxt
);

  logic [SUM_BITS-1:0] acc_r, acc_nxt;
  logic [SUM_BITS-1:0] pub_r;
  logic                brk_r;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_sat;

  // Saturating add of the new sample
  assign sum_wide = {1'b0, acc_r} + (SUM_BITS+1)'(sample);
  assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

  // Next lane state
  always_comb begin
    acc_nxt = acc_r;
    pub_nxt = pub_r;
    brk_nxt = brk_r;
    if (ctrl.publish) begin
      pub_nxt = sum_sat;
      acc_nxt = '0;
    end else if (ctrl.add) begin
      acc_nxt = sum_sat;
    end
    if (ctrl.check) begin
      brk_nxt = (sample > threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pub_r <= '0;
      brk_r <= 1'b0;
    end else if (ctrl.step) begin
      acc_r <= acc_nxt;
      pub_r <= pub_nxt;
      brk_r <= brk_nxt;
    end
  end

endmodule

### hw/rtl/aobd_ctrl.sv
// Phase sequencer: tick timers, sample counter, phase machine and excitation enable.
// Depends on aobd_pkg; drives the lane commands.
module aobd_ctrl
  import aobd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  tick,
  input  logic                  ready_low,
  input  logic [COUNT_BITS-1:0] samples_per_sum,
  input  logic [TIMER_BITS-1:0] timeout_ticks,
  input  logic [TIMER_BITS-1:0] min_conv_ticks,
  output lane_ctrl_t            lane_ctrl,
  output action_t               action,
  output logic                  sums_valid,
  output logic                  current_nxt,
  output phase_t                phase_nxt
);

  phase_t                phase_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_inc;
  logic [TIMER_BITS-1:0] conv_r, conv_nxt, conv_t;
  logic [TIMER_BITS-1:0] tout_r, tout_nxt, tout_t;
  logic                  current_r;
  logic                  conv_ok;
  logic                  last_sample;

  // Timers advance on a tick first, saturating
  assign conv_t = (tick && conv_r != TIMER_MAX) ? conv_r + 1'b1 : conv_r;
  assign tout_t = (tick && tout_r != TIMER_MAX) ? tout_r + 1'b1 : tout_r;

  assign conv_ok     = ready_low && (conv_t >= min_conv_ticks);
  assign count_inc   = count_r + 1'b1;
  assign last_sample = !(count_inc < samples_per_sum);

  // Timer values left by this poll
  always_comb begin
    conv_nxt = conv_t;
    tout_nxt = tout_t;
    case (phase_r)
      PH_MEASURE, PH_CHECK: begin
        if (conv_ok) begin
          conv_nxt = '0;
          tout_nxt = '0;
        end
      end
      default: begin
        conv_nxt = '0;
        tout_nxt = '0;
      end
    endcase
  end

  // Next phase; timeout test sees the timer after any restart
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_MEASURE: begin
        if (conv_ok && last_sample) phase_nxt = PH_CHECK;
        if (tout_nxt >= timeout_ticks) phase_nxt = PH_FAIL;
      end
      PH_CHECK: begin
        if (conv_ok) phase_nxt = PH_MEASURE;
        if (tout_nxt >= timeout_ticks) phase_nxt = PH_FAIL;
      end
      default: phase_nxt = PH_MEASURE;
    endcase
  end

  // Outputs and lane commands
  always_comb begin
    action      = ACT_NONE;
    sums_valid  = 1'b0;
    count_nxt   = count_r;
    current_nxt = current_r;
    lane_ctrl   = '{step: step, add: 1'b0, publish: 1'b0, check: 1'b0};
    case (phase_r)
      PH_MEASURE: begin
        if (conv_ok) begin
          lane_ctrl.add = 1'b1;
          if (last_sample) begin
            lane_ctrl.publish = 1'b1;
            count_nxt         = '0;
            sums_valid        = 1'b1;
            current_nxt       = 1'b1;
            action            = ACT_CHECK;
          end else begin
            count_nxt = count_inc;
            action    = ACT_MEASURE;
          end
        end
      end
      PH_CHECK: begin
        if (conv_ok) begin
          lane_ctrl.check = 1'b1;
          current_nxt     = 1'b0;
          action          = ACT_MEASURE;
        end
      end
      default: begin
        current_nxt = 1'b0;
        action      = ACT_REINIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MEASURE;
      count_r   <= '0;
      conv_r    <= '0;
      tout_r    <= '0;
      current_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      conv_r    <= conv_nxt;
      tout_r    <= tout_nxt;
      current_r <= current_nxt;
    end
  end

endmodule

### hw/rtl/aobd_skid.sv
// Two-entry output buffer: result register plus skid register.
// Depends on aobd_pkg for the default of WIDTH.
module aobd_skid
  import aobd_pkg::*;
#(
  parameter int WIDTH = OUT_DATA_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  input  logic             out_ready
);

  logic             main_vld_r, main_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  logic [WIDTH-1:0] main_r, main_nxt;
  logic [WIDTH-1:0] skid_r, skid_nxt;
  logic             main_free;

  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;
  assign main_free = !main_vld_r || out_ready;

  // Oldest result always sits in the main register
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (main_free) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = push_data;
        main_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### tb/aobd_poll_checker.sv
`timescale 1ns / 100ps
// Result checker for the converter oversampling and wire-break sequencer.
// Watches config writes and both stream channels, predicts each poll result and compares it.
// Depends on aobd_pkg.
module aobd_poll_checker
  import aobd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // tick, ready_low, sample_a, sample_b, sample_c, sample_d (lowest first)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // action, sums_valid, sum_a, sum_b, sum_c, sum_d, break_flags, current_on, phase
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending,
  output int                    n_results,
  output int                    n_publish,
  output int                    n_reinit,
  output int                    n_broken
);

  // Result field offsets in out_tdata
  localparam int VALID_BIT = 2;
  localparam int SUM_LSB   = 3;
  localparam int FLAGS_LSB = SUM_LSB + CHANNELS * SUM_BITS;
  localparam int CUR_BIT   = FLAGS_LSB + CHANNELS;
  localparam int PH_LSB    = CUR_BIT + 1;

  typedef struct packed {
    logic [1:0]                         action;
    logic                               sums_valid;
    logic [CHANNELS-1:0][SUM_BITS-1:0]  sums;
    logic [CHANNELS-1:0]                flags;
    logic                               current_on;
    logic [1:0]                         phase;
  } poll_result_t;

  // Register copies
  logic [SAMPLE_BITS-1:0] thr_r;
  logic [COUNT_BITS-1:0]  per_sum_r;
  logic [TIMER_BITS-1:0]  timeout_r;
  logic [TIMER_BITS-1:0]  min_conv_r;

  // Sequencer state copy
  phase_t                 seq_phase;
  logic [COUNT_BITS-1:0]  set_count;
  logic [SUM_BITS-1:0]    acc [CHANNELS];
  logic [SUM_BITS-1:0]    pub [CHANNELS];
  logic [CHANNELS-1:0]    broken;
  logic [TIMER_BITS-1:0]  conv_timer;
  logic [TIMER_BITS-1:0]  idle_timer;
  logic                   excite_on;

  poll_result_t due_results [$];

  // Advance the state copy by one poll and return what the block should report
  function automatic poll_result_t predict_poll(input logic [IN_DATA_W-1:0] d);
    logic                   take;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SUM_BITS:0]      wide;
    poll_result_t           r;
    r = '0;
    r.action = ACT_NONE;
    if (d[0]) begin
      if (conv_timer != TIMER_MAX) conv_timer = conv_timer + 1'b1;
      if (idle_timer != TIMER_MAX) idle_timer = idle_timer + 1'b1;
    end
    take = d[1] && (conv_timer >= min_conv_r);
    if (seq_phase == PH_MEASURE) begin
      if (take) begin
        conv_timer = '0;
        idle_timer = '0;
        for (int i = 0; i < CHANNELS; i++) begin
          smp  = d[IN_SAMPLE_LSB + i*SAMPLE_BITS +: SAMPLE_BITS];
          wide = {1'b0, acc[i]} + (SUM_BITS+1)'(smp);
          acc[i] = wide[SUM_BITS] ? {SUM_BITS{1'b1}} : wide[SUM_BITS-1:0];
        end
        set_count = set_count + 1'b1;
        if (set_count < per_sum_r) begin
          r.action = ACT_MEASURE;
        end else begin
          for (int i = 0; i < CHANNELS; i++) begin
            pub[i] = acc[i];
            acc[i] = '0;
          end
          set_count    = '0;
          r.sums_valid = 1'b1;
          excite_on    = 1'b1;
          r.action     = ACT_CHECK;
          seq_phase    = PH_CHECK;
        end
      end
      if (idle_timer >= timeout_r) seq_phase = PH_FAIL;
    end else if (seq_phase == PH_CHECK) begin
      if (take) begin
        conv_timer = '0;
        idle_timer = '0;
        for (int i = 0; i < CHANNELS; i++)
          broken[i] = d[IN_SAMPLE_LSB + i*SAMPLE_BITS +: SAMPLE_BITS] > thr_r;
        excite_on = 1'b0;
        r.action  = ACT_MEASURE;
        seq_phase = PH_MEASURE;
      end
      if (idle_timer >= timeout_r) seq_phase = PH_FAIL;
    end else begin
      // failed: samples ignored, converters reinitialised
      conv_timer = '0;
      idle_timer = '0;
      excite_on  = 1'b0;
      r.action   = ACT_REINIT;
      seq_phase  = PH_MEASURE;
    end
    for (int i = 0; i < CHANNELS; i++) r.sums[i] = pub[i];
    r.flags      = broken;
    r.current_on = excite_on;
    r.phase      = seq_phase;
    return r;
  endfunction

  task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", nm, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    poll_result_t want;
    if (!rst_n) begin
      fail_count = 0;
      n_results  = 0;
      n_publish  = 0;
      n_reinit   = 0;
      n_broken   = 0;
      thr_r      = THRESHOLD_RST;
      per_sum_r  = SPS_RST;
      timeout_r  = TIMEOUT_RST;
      min_conv_r = MIN_CONV_RST;
      seq_phase  = PH_MEASURE;
      set_count  = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        acc[i] = '0;
        pub[i] = '0;
      end
      broken     = '0;
      conv_timer = '0;
      idle_timer = '0;
      excite_on  = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          REG_THRESHOLD: thr_r      = cfg_wdata[SAMPLE_BITS-1:0];
          REG_SPS:       per_sum_r  = cfg_wdata[COUNT_BITS-1:0];
          REG_TIMEOUT:   timeout_r  = cfg_wdata[TIMER_BITS-1:0];
          REG_MIN_CONV:  min_conv_r = cfg_wdata[TIMER_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) due_results.push_back(predict_poll(in_tdata));
      if (out_tvalid && out_tready) begin
        n_results++;
        if (due_results.size() == 0) begin
          $error("result transaction with no poll outstanding: %0h", out_tdata);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (want.sums_valid) n_publish++;
          if (want.action == ACT_REINIT) n_reinit++;
          if (want.flags != '0) n_broken++;
          check_field("action", 32'(want.action), 32'(out_tdata[1:0]));
          check_field("sums_valid", 32'(want.sums_valid), 32'(out_tdata[VALID_BIT]));
          for (int i = 0; i < CHANNELS; i++)
            if (want.sums[i] !== out_tdata[SUM_LSB + i*SUM_BITS +: SUM_BITS]) begin
              $error("sum_%c mismatch: expected %0h, actual %0h", 8'h61 + i,
                     want.sums[i], out_tdata[SUM_LSB + i*SUM_BITS +: SUM_BITS]);
              fail_count++;
            end
          check_field("break_flags", 32'(want.flags), 32'(out_tdata[FLAGS_LSB +: CHANNELS]));
          check_field("current_on", 32'(want.current_on), 32'(out_tdata[CUR_BIT]));
          check_field("phase", 32'(want.phase), 32'(out_tdata[PH_LSB +: 2]));
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for adc_oversample_break_detect_sequencer: clock, reset, poll stimulus,
// register writes, result back-pressure and verdict. Depends on aobd_pkg and aobd_poll_checker.
module tb_top;
  import aobd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {SAMPLE_BITS{1'b1}};

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count, pending, n_results, n_publish, n_reinit, n_broken;
  int send_gap_pct = 27;
  int recv_gap_pct = 59;
  int n_configs    = 1;
  logic [SAMPLE_BITS-1:0] cur_thr = THRESHOLD_RST;

  adc_oversample_break_detect_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  aobd_poll_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_publish  (n_publish),
    .n_reinit   (n_reinit),
    .n_broken   (n_broken)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Watchdog on cycles with no transaction of any kind
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_poll(
    input logic tick, input logic rdy,
    input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
    input logic [SAMPLE_BITS-1:0] c, input logic [SAMPLE_BITS-1:0] d);
    logic [IN_DATA_W-1:0] v;
    v = '0;
    v[0] = tick;
    v[1] = rdy;
    v[IN_SAMPLE_LSB + 0*SAMPLE_BITS +: SAMPLE_BITS] = a;
    v[IN_SAMPLE_LSB + 1*SAMPLE_BITS +: SAMPLE_BITS] = b;
    v[IN_SAMPLE_LSB + 2*SAMPLE_BITS +: SAMPLE_BITS] = c;
    v[IN_SAMPLE_LSB + 3*SAMPLE_BITS +: SAMPLE_BITS] = d;
    return v;
  endfunction

  // Sample values biased toward the rails and the threshold edge
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int big_pct);
    logic [SAMPLE_BITS-1:0] s;
    if ($urandom_range(99) < big_pct)
      return SMP_MAX - SAMPLE_BITS'($urandom_range(255));
    case ($urandom_range(7))
      0: s = '0;
      1: s = SMP_MAX;
      2: s = cur_thr;
      3: s = cur_thr + 1'b1;
      4: s = cur_thr - 1'b1;
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  task automatic send_poll(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every result is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // One configuration followed by a burst of random polls
  task automatic run_config(
    input logic [SAMPLE_BITS-1:0] thr, input logic [COUNT_BITS-1:0] sps,
    input logic [TIMER_BITS-1:0] tmo, input logic [TIMER_BITS-1:0] minc,
    input int polls, input int big_pct, input bit mid_pause);
    int dry_left;
    logic tick, rdy;
    dry_left = 0;
    drain();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_SPS,       CFG_DATA_W'(sps));
    write_reg(REG_TIMEOUT,   CFG_DATA_W'(tmo));
    write_reg(REG_MIN_CONV,  CFG_DATA_W'(minc));
    cfg_wr_en <= 1'b0;
    cur_thr = thr;
    n_configs++;
    for (int n = 0; n < polls; n++) begin
      if (mid_pause && n == polls / 2) drain();
      // occasional stretch of ticks with no conversion, to hit the timeout
      if (dry_left == 0 && $urandom_range(99) < 3) dry_left = $urandom_range(15, 2);
      if (dry_left != 0) begin
        dry_left--;
        tick = 1'b1;
        rdy  = 1'b0;
      end else begin
        tick = ($urandom_range(99) < 60);
        rdy  = ($urandom_range(99) < 55);
      end
      send_poll(pack_poll(tick, rdy, pick_sample(big_pct), pick_sample(big_pct),
                          pick_sample(big_pct), pick_sample(big_pct)));
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset configuration, one full oversampling cycle, break check,
    // timeout into the failed phase and reinitialisation
    send_poll(pack_poll(1'b0, 1'b1, '0, '0, '0, '0));
    send_poll(pack_poll(1'b1, 1'b1, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
    repeat (6) send_poll(pack_poll(1'b1, 1'b1, '0, SMP_MAX, 24'h5A5A5A, 24'hA5A5A5));
    send_poll(pack_poll(1'b1, 1'b1, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
    send_poll(pack_poll(1'b0, 1'b1, THRESHOLD_RST + 1'b1, THRESHOLD_RST, '0, SMP_MAX));
    send_poll(pack_poll(1'b1, 1'b1, THRESHOLD_RST + 1'b1, THRESHOLD_RST, '0, SMP_MAX));
    repeat (10) send_poll(pack_poll(1'b1, 1'b0, 24'h123456, '0, SMP_MAX, 24'h654321));
    send_poll(pack_poll(1'b0, 1'b1, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
    send_poll(pack_poll(1'b1, 1'b1, 24'd1, 24'd2, 24'd3, 24'd4));

    // Random: threshold at zero, publish on every set, slow timeout
    run_config(24'h000000, 4'd1, 8'd255, 8'd0, 110, 0, 1'b1);

    // Roles of sender and receiver swapped; long sums of large samples saturate
    send_gap_pct = 59;
    recv_gap_pct = 27;
    run_config(SMP_MAX, 4'd15, 8'd255, 8'd0, 110, 80, 1'b0);

    // No idling from here on; zero timeout fails on every measuring poll
    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_config(24'h5A5A5A, 4'd0, 8'd0, 8'd255, 15, 0, 1'b0);
    run_config(24'h123456, 4'd0, 8'd0, 8'd0, 20, 0, 1'b0);
    run_config(24'h800000, 4'd4, 8'd3, 8'd2, 110, 0, 1'b0);
    run_config(THRESHOLD_RST, 4'd9, 8'd1, 8'd1, 40, 30, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d poll results across %0d register configurations.",
             n_results, n_configs);
    $display("Sums published %0d times, %0d reinitialisations, %0d results with broken wires.",
             n_publish, n_reinit, n_broken);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/aobd_pkg.sv
hw/rtl/aobd_lane.sv
hw/rtl/aobd_ctrl.sv
hw/rtl/aobd_skid.sv
hw/rtl/adc_oversample_break_detect_sequencer.sv
tb/aobd_poll_checker.sv
tb/tb_top.sv
